/* rtl/core/vsa_pkg.sv */
// shared types, widths and codes for the voice slot allocator
`default_nettype none

package vsa_pkg;

  // field widths
  localparam int MODE_W = 3;
  localparam int PRIO_W = 8;
  localparam int ENT_W  = 11;
  localparam int CHAN_W = 5;
  localparam int TIME_W = 31;
  localparam int SLOT_W = 7;
  localparam int KIND_W = 2;
  localparam int CFG_W  = 8;

  // table size default and config reset
  localparam int              NUM_SLOTS_DEF = 128;
  localparam logic [CFG_W-1:0] SLOTS_RST    = 8'd128;

  // request modes
  localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FINISH   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOCK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UNLOCK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOP_ALL = 3'd4;

  // grant kinds
  localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STEAL = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // register word index
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] last_use;
    logic [ENT_W-1:0]  entity;
    logic [CHAN_W-1:0] channel;
  } vsa_rec_t;

  localparam vsa_rec_t CLEAR_REC = '{prio: '0, last_use: '0, entity: '1, channel: '1};

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan_step;
    logic grant;
    logic slot_op;
    logic sweep_step;
  } vsa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              scan_done;
    logic              sweep_done;
  } vsa_stat_t;

endpackage

`default_nettype wire

/* rtl/core/voice_slot_allocator.sv */
// top level of the voice slot allocator: register port, output stage, core
//
// One request enters on the in_ stream, one result leaves on the out_ stream.
// in_tuser carries the mode (allocate, voice finished, lock, unlock, stop all);
// in_tdata carries priority, entity, channel, time and target slot.
// out_tdata carries granted and slot_index, out_tuser the grant kind.
// Register slots_in_use sits at byte address 0 of the cfg_ port; the table
// count used is min(slots_in_use, NUM_SLOTS), called n below.
// Steps from request accept to out_tvalid:
//   allocate        one table read per slot through the single read port,
//                   then one write-back if a slot is granted
//   stop all        one slot cleared per cycle through the write port, locked slots skipped
//   finished, lock, unlock: one slot operation;  unknown mode: no table access
// The block takes one request at a time; in_tready returns high in the same
// cycle as the result appears in the output register.
// If the receiver stalls, the result waits in the output register; the next
// request is still taken and worked on, and only its own result waits until
// the output register is free.
// Reset empties the table (every slot inactive, unlocked, zero) at once and
// sets slots_in_use to 128; no clearing pass is needed.
`default_nettype none

module voice_slot_allocator import vsa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // request_priority, entity, channel_id, now_ms, slot
  input  wire logic [2:0]  in_tuser,   // mode
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // granted, slot_index
  output logic [1:0]       out_tuser,  // grant_kind
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [CFG_W-1:0] slots_r;
  logic [CNT_W-1:0] slot_cnt;
  logic             cfg_wr;

  vsa_cmd_t  cmd;
  vsa_stat_t stat;
  logic      push, out_space;

  logic              res_granted;
  logic [SLOT_W-1:0] res_slot_index;
  logic [KIND_W-1:0] res_kind;

  logic              out_valid_r;
  logic [7:0]        out_data_r;
  logic [KIND_W-1:0] out_kind_r;

  // register port, always ready
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_SLOTS_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RST;
    end else if (cfg_wr) begin
      slots_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SLOTS_IN_USE) begin
      cfg_prdata = 32'(slots_r);
    end
  end

  // saturate the register to the table size
  always_comb begin
    if ((CFG_W + 1)'(slots_r) >= (CFG_W + 1)'(NUM_SLOTS)) begin
      slot_cnt = CNT_W'(NUM_SLOTS);
    end else begin
      slot_cnt = CNT_W'(slots_r);
    end
  end

  // output register frees as the downstream side takes it
  assign out_space = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= {res_slot_index, res_granted};
      out_kind_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  vsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_space (out_space),
    .stat      (stat),
    .cmd       (cmd),
    .push      (push)
  );

  // request field unpack, lowest field first
  vsa_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .slot_cnt       (slot_cnt),
    .in_mode        (in_tuser),
    .in_prio        (in_tdata[7:0]),
    .in_entity      (in_tdata[18:8]),
    .in_channel     (in_tdata[23:19]),
    .in_now         (in_tdata[54:24]),
    .in_slot        (in_tdata[61:55]),
    .res_granted    (res_granted),
    .res_slot_index (res_slot_index),
    .res_kind       (res_kind)
  );

endmodule

`default_nettype wire

/* rtl/core/vsa_dp.sv */
// voice slot table, scan logic and result register
`default_nettype none

module vsa_dp import vsa_pkg::*; #(
  parameter  int NUM_SLOTS = NUM_SLOTS_DEF,
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire vsa_cmd_t          cmd,
  output vsa_stat_t              stat,
  input  wire logic [CNT_W-1:0]  slot_cnt,
  input  wire logic [MODE_W-1:0] in_mode,
  input  wire logic [PRIO_W-1:0] in_prio,
  input  wire logic [ENT_W-1:0]  in_entity,
  input  wire logic [CHAN_W-1:0] in_channel,
  input  wire logic [TIME_W-1:0] in_now,
  input  wire logic [SLOT_W-1:0] in_slot,
  output logic                   res_granted,
  output logic [SLOT_W-1:0]      res_slot_index,
  output logic [KIND_W-1:0]      res_kind
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  // captured request
  logic [MODE_W-1:0] mode_r;
  logic [PRIO_W-1:0] prio_r;
  logic [ENT_W-1:0]  ent_r;
  logic [CHAN_W-1:0] chan_r;
  logic [TIME_W-1:0] now_r;
  logic [SLOT_W-1:0] tgt_r;

  // per-slot flags, entry not yet written reads as all zero
  logic [NUM_SLOTS-1:0] valid_r;
  logic [NUM_SLOTS-1:0] active_r;
  logic [NUM_SLOTS-1:0] locked_r;

  vsa_rec_t mem [NUM_SLOTS];
  vsa_rec_t rd_rec_r;
  logic     rd_valid_r, rd_act_r, rd_lock_r, rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // scan state
  logic              have_match_r, have_empty_r, have_weak_r;
  logic [IDX_W-1:0]  match_idx_r, empty_idx_r, weak_idx_r;
  logic [PRIO_W-1:0] wprio_r;
  logic [TIME_W-1:0] wtime_r;

  logic              res_granted_r;
  logic [IDX_W-1:0]  res_idx_r;
  logic [KIND_W-1:0] res_kind_r;

  logic [IDX_W-1:0]  cnt_idx, tgt_idx, grant_idx, wr_addr;
  logic              tgt_ok, cnt_lt, issue, ev_on, is_match, is_weaker;
  logic              sweep_wr, fin_wr, wr_en, wr_act, lock_op;
  logic [KIND_W-1:0] grant_kind;
  vsa_rec_t          ev_rec, wr_rec;

  assign cnt_idx = cnt_r[IDX_W-1:0];
  assign tgt_idx = IDX_W'(tgt_r);
  assign tgt_ok  = CMP_W'(tgt_r) < CMP_W'(slot_cnt);
  assign cnt_lt  = cnt_r < slot_cnt;
  assign issue   = cmd.scan_step && cnt_lt;
  assign cnt_nxt = cnt_r + CNT_W'(1);

  // evaluate the slot read last cycle
  assign ev_rec    = rd_valid_r ? rd_rec_r : '0;
  assign ev_on     = cmd.scan_step && rd_vld_r && !rd_lock_r && !have_match_r;
  assign is_match  = (ev_rec.entity == ent_r) && (ev_rec.channel == chan_r) &&
                     (chan_r != '0);
  assign is_weaker = (ev_rec.prio < wprio_r) ||
                     ((ev_rec.prio == wprio_r) && (ev_rec.last_use < wtime_r));

  always_comb begin
    grant_kind = KIND_NONE;
    grant_idx  = '0;
    if (have_match_r) begin
      grant_kind = KIND_MATCH;
      grant_idx  = match_idx_r;
    end else if (have_empty_r) begin
      grant_kind = KIND_FREE;
      grant_idx  = empty_idx_r;
    end else if (have_weak_r) begin
      grant_kind = KIND_STEAL;
      grant_idx  = weak_idx_r;
    end
  end

  assign sweep_wr = cmd.sweep_step && cnt_lt && !locked_r[cnt_idx];
  assign fin_wr   = cmd.slot_op && (mode_r == MODE_FINISH) && tgt_ok && !locked_r[tgt_idx];
  assign lock_op  = cmd.slot_op && tgt_ok &&
                    ((mode_r == MODE_LOCK) || (mode_r == MODE_UNLOCK));

  // single write port
  always_comb begin
    wr_en   = 1'b0;
    wr_act  = 1'b0;
    wr_addr = '0;
    wr_rec  = CLEAR_REC;
    if (cmd.grant && (grant_kind != KIND_NONE)) begin
      wr_en   = 1'b1;
      wr_act  = 1'b1;
      wr_addr = grant_idx;
      wr_rec  = '{prio: prio_r, last_use: now_r, entity: ent_r, channel: chan_r};
    end else if (fin_wr) begin
      wr_en   = 1'b1;
      wr_addr = tgt_idx;
    end else if (sweep_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    rd_rec_r   <= mem[cnt_idx];
    rd_valid_r <= valid_r[cnt_idx];
    rd_act_r   <= active_r[cnt_idx];
    rd_lock_r  <= locked_r[cnt_idx];
    rd_idx_r   <= cnt_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      active_r <= '0;
      locked_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr]  <= 1'b1;
      active_r[wr_addr] <= wr_act;
      locked_r[wr_addr] <= 1'b0;
    end else if (lock_op) begin
      locked_r[tgt_idx] <= (mode_r == MODE_LOCK);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      prio_r <= in_prio;
      ent_r  <= in_entity;
      chan_r <= in_channel;
      now_r  <= in_now;
      tgt_r  <= in_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (issue || (cmd.sweep_step && cnt_lt)) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // running best candidates, frozen once a match is seen
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_match_r <= 1'b0;
      have_empty_r <= 1'b0;
      have_weak_r  <= 1'b0;
    end else if (cmd.load) begin
      have_match_r <= 1'b0;
      have_empty_r <= 1'b0;
      have_weak_r  <= 1'b0;
    end else if (ev_on) begin
      if (!rd_act_r && !have_empty_r) begin
        have_empty_r <= 1'b1;
      end
      if (is_weaker) begin
        have_weak_r <= 1'b1;
      end
      if (is_match) begin
        have_match_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wprio_r <= in_prio;
      wtime_r <= in_now;
    end else if (ev_on) begin
      if (!rd_act_r && !have_empty_r) begin
        empty_idx_r <= rd_idx_r;
      end
      if (is_weaker) begin
        wprio_r    <= ev_rec.prio;
        wtime_r    <= ev_rec.last_use;
        weak_idx_r <= rd_idx_r;
      end
      if (is_match) begin
        match_idx_r <= rd_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_granted_r <= 1'b0;
      res_idx_r     <= '0;
      res_kind_r    <= KIND_NONE;
    end else if (cmd.load) begin
      res_granted_r <= 1'b0;
      res_idx_r     <= '0;
      res_kind_r    <= KIND_NONE;
    end else if (cmd.grant) begin
      res_granted_r <= (grant_kind != KIND_NONE);
      res_idx_r     <= grant_idx;
      res_kind_r    <= grant_kind;
    end else if (cmd.slot_op) begin
      if (mode_r == MODE_FINISH) begin
        res_granted_r <= fin_wr;
      end else begin
        res_granted_r <= lock_op;
      end
    end else if (cmd.sweep_step) begin
      res_granted_r <= 1'b1;
    end
  end

  assign res_granted    = res_granted_r;
  assign res_slot_index = SLOT_W'(res_idx_r);
  assign res_kind       = res_kind_r;

  assign stat.mode       = mode_r;
  assign stat.scan_done  = !cnt_lt && !rd_vld_r;
  assign stat.sweep_done = !cnt_lt;

  // no write of any kind may land on a locked slot
  a_wr_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !locked_r[wr_addr])
    else $error("slot write hit a locked slot");

  // a matched reuse needs a nonzero request channel
  a_match_chan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.grant && have_match_r) |-> (chan_r != '0))
    else $error("match found with zero channel");

  // the slot counter never runs past the table count while walking
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step || cmd.sweep_step) |-> (cnt_r <= slot_cnt))
    else $error("slot counter out of range");

  // the scan only finishes after its last read has been evaluated
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_step && rd_vld_r) |=> !(cmd.grant && !$past(cmd.load) && rd_vld_r))
    else $error("grant issued with a read still in flight");

endmodule

`default_nettype wire

/* rtl/core/vsa_ctrl.sv */
// request sequencer for the voice slot allocator
`default_nettype none

module vsa_ctrl import vsa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire logic      out_space,
  input  wire vsa_stat_t stat,
  output vsa_cmd_t       cmd,
  output logic           push
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_GRANT  = 3'd3;
  localparam logic [2:0] S_CMD    = 3'd4;
  localparam logic [2:0] S_SWEEP  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready      = (state_r == S_IDLE);
  assign cmd.load       = in_tvalid && in_tready;
  assign cmd.scan_step  = (state_r == S_SCAN);
  assign cmd.grant      = (state_r == S_GRANT);
  assign cmd.slot_op    = (state_r == S_CMD);
  assign cmd.sweep_step = (state_r == S_SWEEP);
  assign push           = (state_r == S_DONE) && out_space;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (stat.mode)
          MODE_ALLOC:                            state_nxt = S_SCAN;
          MODE_FINISH, MODE_LOCK, MODE_UNLOCK:   state_nxt = S_CMD;
          MODE_STOP_ALL:                         state_nxt = S_SWEEP;
          default:                               state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_GRANT;
      end
      S_GRANT: state_nxt = S_DONE;
      S_CMD:   state_nxt = S_DONE;
      S_SWEEP: begin
        if (stat.sweep_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_space) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
